[rtl/pisl_pkg.sv]
// Shared types, constants and saturation helpers for the smoothed PI speed loop.
package pisl_pkg;

	typedef enum logic {
		ACT_UPDATE = 1'b0,
		ACT_STEP   = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		REG_TARGET    = 2'd0,
		REG_PROP_GAIN = 2'd1,
		REG_INT_GAIN  = 2'd2
	} reg_idx_t;

	localparam int STEP_W      = 5;
	localparam int ACC_W       = 48;
	localparam int GAIN_W      = 32;
	localparam int GAIN_FRAC_W = 22;
	localparam int ERR_MAG_W   = 28;
	localparam int GPROD_W     = 38;
	localparam int DRIVE_W     = 16;

	localparam logic signed [7:0]  TARGET_RESET    = 8'sd0;
	localparam logic [GAIN_W-1:0]  PROP_GAIN_RESET = 32'd180355072;
	localparam logic [GAIN_W-1:0]  INT_GAIN_RESET  = 32'd4194;

	// Counts to signed Q12.16 speed: 65536 / 40 = 1638 + 2/5, with 1/5 taken as 52429 / 2^18.
	localparam logic [10:0] SPEED_SCALE = 11'd1638;
	localparam logic [15:0] FIFTH_RECIP = 16'd52429;
	localparam int          FIFTH_SHIFT = 18;

	localparam int DIV_CHUNK_W     = 12;
	localparam int DIV_RECIP_SHIFT = 24;

	function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W:0] v);
		logic signed [ACC_W-1:0] r;
		if (v[ACC_W] != v[ACC_W-1]) begin
			r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r = v[ACC_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [DRIVE_W-1:0] sat16(input logic signed [33:0] v);
		logic signed [DRIVE_W-1:0] r;
		if (v[33:DRIVE_W-1] != {(34-DRIVE_W+1){v[33]}}) begin
			r = v[33] ? {1'b1, {(DRIVE_W-1){1'b0}}} : {1'b0, {(DRIVE_W-1){1'b1}}};
		end else begin
			r = v[DRIVE_W-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/pisl_cdiv.sv]
// Pipelined division by a constant, one twelve-bit quotient digit per stage.
module pisl_cdiv
	import pisl_pkg::*;
#(
	parameter int WIDTH   = 53,
	parameter int DIVISOR = 20,
	parameter int TAG_W   = 49
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             arg_valid,
	output logic             arg_ready,
	input  logic [WIDTH-1:0] arg_num,
	input  logic [TAG_W-1:0] arg_tag,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [WIDTH-1:0] res_quo,
	output logic [TAG_W-1:0] res_tag
);

	localparam int NCH  = (WIDTH + DIV_CHUNK_W - 1) / DIV_CHUNK_W;
	localparam int PADW = NCH * DIV_CHUNK_W;
	localparam int RW   = $clog2(DIVISOR + 1);
	localparam int VW   = RW + DIV_CHUNK_W;
	localparam int PW   = VW + DIV_RECIP_SHIFT + 1;
	localparam logic [DIV_RECIP_SHIFT:0] RECIP =
		(DIV_RECIP_SHIFT + 1)'(((1 << DIV_RECIP_SHIFT) + DIVISOR - 1) / DIVISOR);
	localparam logic [RW-1:0] DIV_C = RW'(DIVISOR);

	logic             vld_q [NCH];
	logic [PADW-1:0]  num_q [NCH];
	logic [PADW-1:0]  quo_q [NCH];
	logic [RW-1:0]    rem_q [NCH];
	logic [TAG_W-1:0] tag_q [NCH];

	logic             rdy   [NCH+1];
	logic             f_vld [NCH];
	logic [PADW-1:0]  f_num [NCH];
	logic [PADW-1:0]  f_quo [NCH];
	logic [RW-1:0]    f_rem [NCH];
	logic [TAG_W-1:0] f_tag [NCH];

	logic [VW-1:0]          v_w     [NCH];
	logic [PW-1:0]          prod_w  [NCH];
	logic [DIV_CHUNK_W-1:0] digit_w [NCH];
	logic [PADW-1:0]        quo_n   [NCH];
	logic [RW-1:0]          rem_n   [NCH];

	always_comb begin
		rdy[NCH] = res_ready;
		for (int j = NCH - 1; j >= 0; j--) begin
			rdy[j] = !vld_q[j] || rdy[j+1];
		end
		f_vld[0] = arg_valid;
		f_num[0] = PADW'(arg_num);
		f_quo[0] = '0;
		f_rem[0] = '0;
		f_tag[0] = arg_tag;
		for (int j = 1; j < NCH; j++) begin
			f_vld[j] = vld_q[j-1];
			f_num[j] = num_q[j-1];
			f_quo[j] = quo_q[j-1];
			f_rem[j] = rem_q[j-1];
			f_tag[j] = tag_q[j-1];
		end
		for (int j = 0; j < NCH; j++) begin
			v_w[j]     = {f_rem[j], f_num[j][PADW-1-j*DIV_CHUNK_W -: DIV_CHUNK_W]};
			prod_w[j]  = PW'(v_w[j]) * PW'(RECIP);
			digit_w[j] = prod_w[j][DIV_RECIP_SHIFT +: DIV_CHUNK_W];
			rem_n[j]   = RW'(v_w[j] - VW'(digit_w[j]) * VW'(DIV_C));
			quo_n[j]   = f_quo[j];
			quo_n[j][PADW-1-j*DIV_CHUNK_W -: DIV_CHUNK_W] = digit_w[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NCH; j++) begin
				vld_q[j] <= 1'b0;
			end
		end else begin
			for (int j = 0; j < NCH; j++) begin
				if (rdy[j]) begin
					vld_q[j] <= f_vld[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NCH; j++) begin
			if (f_vld[j] && rdy[j]) begin
				num_q[j] <= f_num[j];
				quo_q[j] <= quo_n[j];
				rem_q[j] <= rem_n[j];
				tag_q[j] <= f_tag[j];
			end
		end
	end

	assign arg_ready = rdy[0];
	assign res_valid = vld_q[NCH-1];
	assign res_quo   = quo_q[NCH-1][WIDTH-1:0];
	assign res_tag   = tag_q[NCH-1];

endmodule

[rtl/pi_speed_loop_smoothed_unit.sv]
// Top level of the wheel speed PI loop with interpolated drive output.
//
//  Channel   Signals                                         Direction  Flow control
//  item      action left_count right_count sub_step          in         item_valid / item_stall
//  drive     drive                                           out        drive_valid / drive_stall
//  cfg       cfg_index cfg_data                              in         cfg_valid / cfg_ready
//
// One item enters per cycle while item_stall is low. A sub-step transaction passes through
// fourteen registers on its way to the drive output: seven arithmetic stages, five
// quotient-digit stages of the divider and two output stages. An update transaction gives
// no result and leaves the pipe after its fifth stage. Reset clears the loop state and the
// target and loads the default gains.
// While drive_stall is high, items keep filling empty stages; item_stall rises only once
// every stage holds a transaction.
module pi_speed_loop_smoothed_unit
	import pisl_pkg::*;
#(
	parameter int SUB_STEPS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic                      action,
	input  logic signed [15:0]        left_count,
	input  logic signed [15:0]        right_count,
	input  logic [STEP_W-1:0]         sub_step,
	output logic                      drive_valid,
	input  logic                      drive_stall,
	output logic signed [DRIVE_W-1:0] drive,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [GAIN_W-1:0]         cfg_data
);

	localparam int STEP_LIM = (SUB_STEPS < (1 << STEP_W) - 1) ? SUB_STEPS : (1 << STEP_W) - 1;
	localparam logic [STEP_W-1:0] STEP_CAP = STEP_W'(STEP_LIM);
	localparam int PROD_W = ACC_W + STEP_W;
	localparam int TAG_W  = ACC_W + 1;

	logic signed [7:0]        target_q;
	logic [GAIN_W-1:0]        prop_gain_q;
	logic [GAIN_W-1:0]        int_gain_q;
	logic signed [ACC_W-1:0]  integ_q;
	logic signed [ACC_W-1:0]  prev_cmd_q;
	logic signed [ACC_W-1:0]  new_cmd_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, drive_vld_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8, rdy_o;
	logic div_ready, div_valid;

	action_t                  act_s1, act_s2, act_s3, act_s4, act_s5;
	logic [STEP_W-1:0]        step_s1, step_s2, step_s3, step_s4, step_s5, step_s6;
	logic signed [16:0]       sum_s1;
	logic signed [27:0]       speed_s2;
	logic                     err_neg_s3;
	logic [ERR_MAG_W-1:0]     err_mag_s3;
	logic signed [GPROD_W:0]  gi_s4, gp_s4, gp_s5;
	logic signed [ACC_W-1:0]  integ_s5;
	logic                     neg_s6, neg_s7;
	logic [ACC_W-1:0]         mag_s6;
	logic signed [ACC_W-1:0]  prev_s6, prev_s7;
	logic [PROD_W-1:0]        prod_s7;
	logic signed [ACC_W+1:0]  qsum_s8;
	logic signed [DRIVE_W-1:0] drive_q;

	logic [STEP_W-1:0]        step_in;
	logic                     sum_neg;
	logic [16:0]              sum_mag;
	logic [33:0]              fifth_full;
	logic [27:0]              speed_mag;
	logic signed [27:0]       speed_n;
	logic signed [28:0]       err_w;
	logic [59:0]              pi_full, pp_full;
	logic [GPROD_W-1:0]       pi_mag, pp_mag;
	logic signed [GPROD_W:0]  gi_n, gp_n;
	logic signed [ACC_W-1:0]  integ_n, cmd_n;
	logic signed [ACC_W:0]    diff_w;
	logic [PROD_W-1:0]        div_quo;
	logic [TAG_W-1:0]         div_tag;
	logic [ACC_W-1:0]         q_mag;
	logic signed [ACC_W+1:0]  q_signed;
	logic signed [ACC_W+1:0]  qsum_n;
	logic signed [33:0]       whole_w;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= TARGET_RESET;
			prop_gain_q <= PROP_GAIN_RESET;
			int_gain_q  <= INT_GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TARGET:    target_q    <= cfg_data[7:0];
				REG_PROP_GAIN: prop_gain_q <= cfg_data;
				REG_INT_GAIN:  int_gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rdy_o = !drive_vld_q || !drive_stall;
	assign rdy8  = !vld_s8 || rdy_o;
	assign rdy7  = !vld_s7 || div_ready;
	assign rdy6  = !vld_s6 || rdy7;
	assign rdy5  = !vld_s5 || rdy6;
	assign rdy4  = !vld_s4 || rdy5;
	assign rdy3  = !vld_s3 || rdy4;
	assign rdy2  = !vld_s2 || rdy3;
	assign rdy1  = !vld_s1 || rdy2;
	assign item_stall = !rdy1;

	always_comb begin
		step_in   = (sub_step > STEP_CAP) ? STEP_CAP : sub_step;
		sum_neg   = sum_s1[16];
		sum_mag   = sum_neg ? 17'(-sum_s1) : 17'(sum_s1);
		fifth_full = 34'({sum_mag, 1'b0}) * 34'(FIFTH_RECIP);
		speed_mag = 28'(sum_mag) * 28'(SPEED_SCALE) + 28'(fifth_full >> FIFTH_SHIFT);
		speed_n   = sum_neg ? -$signed(speed_mag) : $signed(speed_mag);
		err_w     = {{5{target_q[7]}}, target_q, 16'h0000} - {speed_s2[27], speed_s2};
		pi_full   = 60'(err_mag_s3) * 60'(int_gain_q);
		pp_full   = 60'(err_mag_s3) * 60'(prop_gain_q);
		pi_mag    = pi_full[GAIN_FRAC_W +: GPROD_W];
		pp_mag    = pp_full[GAIN_FRAC_W +: GPROD_W];
		gi_n      = err_neg_s3 ? -$signed({1'b0, pi_mag}) : $signed({1'b0, pi_mag});
		gp_n      = err_neg_s3 ? -$signed({1'b0, pp_mag}) : $signed({1'b0, pp_mag});
		integ_n   = sat48({integ_q[ACC_W-1], integ_q}
			+ {{(ACC_W - GPROD_W){gi_s4[GPROD_W]}}, gi_s4});
		cmd_n     = sat48({{(ACC_W - GPROD_W){gp_s5[GPROD_W]}}, gp_s5}
			+ {integ_s5[ACC_W-1], integ_s5});
		diff_w    = {new_cmd_q[ACC_W-1], new_cmd_q} - {prev_cmd_q[ACC_W-1], prev_cmd_q};
		q_mag     = div_quo[ACC_W-1:0];
		q_signed  = div_tag[ACC_W] ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
		qsum_n    = {{2{div_tag[ACC_W-1]}}, div_tag[ACC_W-1:0]} + q_signed;
		whole_w   = qsum_s8[ACC_W+1:16]
			+ 34'(qsum_s8[ACC_W+1] && (qsum_s8[15:0] != 16'h0000));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			vld_s7      <= 1'b0;
			vld_s8      <= 1'b0;
			drive_vld_q <= 1'b0;
			integ_q     <= '0;
			prev_cmd_q  <= '0;
			new_cmd_q   <= '0;
		end else begin
			if (rdy1) vld_s1 <= item_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5 && (act_s5 == ACT_STEP);
			if (rdy7) vld_s7 <= vld_s6;
			if (rdy8) vld_s8 <= div_valid;
			if (rdy_o) drive_vld_q <= vld_s8;
			if (vld_s4 && rdy5 && (act_s4 == ACT_UPDATE)) begin
				integ_q <= integ_n;
			end
			if (vld_s5 && rdy6 && (act_s5 == ACT_UPDATE)) begin
				prev_cmd_q <= new_cmd_q;
				new_cmd_q  <= cmd_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && rdy1) begin
			act_s1  <= action_t'(action);
			sum_s1  <= {left_count[15], left_count} + {right_count[15], right_count};
			step_s1 <= step_in;
		end
		if (vld_s1 && rdy2) begin
			act_s2   <= act_s1;
			speed_s2 <= speed_n;
			step_s2  <= step_s1;
		end
		if (vld_s2 && rdy3) begin
			act_s3     <= act_s2;
			err_neg_s3 <= err_w[28];
			err_mag_s3 <= err_w[28] ? ERR_MAG_W'(-err_w) : ERR_MAG_W'(err_w);
			step_s3    <= step_s2;
		end
		if (vld_s3 && rdy4) begin
			act_s4  <= act_s3;
			gi_s4   <= gi_n;
			gp_s4   <= gp_n;
			step_s4 <= step_s3;
		end
		if (vld_s4 && rdy5) begin
			act_s5   <= act_s4;
			gp_s5    <= gp_s4;
			integ_s5 <= integ_n;
			step_s5  <= step_s4;
		end
		if (vld_s5 && rdy6) begin
			neg_s6  <= diff_w[ACC_W];
			mag_s6  <= diff_w[ACC_W] ? ACC_W'(-diff_w) : ACC_W'(diff_w);
			prev_s6 <= prev_cmd_q;
			step_s6 <= step_s5;
		end
		if (vld_s6 && rdy7) begin
			neg_s7  <= neg_s6;
			prev_s7 <= prev_s6;
			prod_s7 <= PROD_W'(mag_s6) * PROD_W'(step_s6);
		end
		if (div_valid && rdy8) begin
			qsum_s8 <= qsum_n;
		end
		if (vld_s8 && rdy_o) begin
			drive_q <= sat16(whole_w);
		end
	end

	pisl_cdiv #(
		.WIDTH   (PROD_W),
		.DIVISOR (SUB_STEPS),
		.TAG_W   (TAG_W)
	) u_cdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.arg_valid (vld_s7),
		.arg_ready (div_ready),
		.arg_num   (prod_s7),
		.arg_tag   ({neg_s7, prev_s7}),
		.res_valid (div_valid),
		.res_ready (rdy8),
		.res_quo   (div_quo),
		.res_tag   (div_tag)
	);

	assign drive_valid = drive_vld_q;
	assign drive       = drive_q;

	a_no_stall_without_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!drive_stall |-> !item_stall)
		else $error("Input stalled while the output side is free.");

	a_command_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && rdy6 && (act_s5 == ACT_UPDATE)) |=> (prev_cmd_q == $past(new_cmd_q)))
		else $error("Previous command does not take the old new command on update.");

	a_result_from_last_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drive_valid) |-> $past(vld_s8))
		else $error("Drive valid rose without a transaction in the last stage.");

endmodule
